// ----- design/vfc_pkg.sv -----
// ----------------------------------------------------------------------------
// vfc_pkg - shared types and constants for the voxel face culling core
// Transaction structs, face codes, grid defaults and the block color table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vfc_pkg;

  // Fixed field widths
  localparam int unsigned COORD_W     = 5;
  localparam int unsigned COORD_RANGE = 1 << COORD_W;
  localparam int unsigned LOCAL_W     = 4;
  localparam int unsigned LOCAL_RANGE = 1 << LOCAL_W;
  localparam int unsigned VALUE_W     = 8;
  localparam int unsigned FACE_W      = 3;
  localparam int unsigned NUM_FACES   = 6;

  // Parameter defaults
  localparam int unsigned GRID_X_DEF  = 32;
  localparam int unsigned GRID_Y_DEF  = 32;
  localparam int unsigned GRID_Z_DEF  = 32;
  localparam int unsigned CHUNK_X_DEF = 16;
  localparam int unsigned CHUNK_Z_DEF = 16;

  // Input kind codes
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Face directions, in emission order
  typedef enum logic [FACE_W-1:0] {
    FACE_NEG_X = 3'd0,
    FACE_POS_X = 3'd1,
    FACE_NEG_Y = 3'd2,
    FACE_POS_Y = 3'd3,
    FACE_NEG_Z = 3'd4,
    FACE_POS_Z = 3'd5
  } face_e;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [COORD_W-1:0] pos_z;
    logic [VALUE_W-1:0] block_value;
  } in_item_t;

  typedef struct packed {
    logic [FACE_W-1:0]  face;
    logic [LOCAL_W-1:0] local_x;
    logic [COORD_W-1:0] local_y;
    logic [LOCAL_W-1:0] local_z;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               last;
  } out_item_t;

  // Request to the shared neighbor address unit
  typedef struct packed {
    logic               self_sel;
    face_e              face;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } nbr_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam logic [VALUE_W-1:0] BLOCK_GRASS = 8'd1;
  localparam logic [VALUE_W-1:0] BLOCK_DIRT  = 8'd2;
  localparam logic [VALUE_W-1:0] BLOCK_STONE = 8'd3;

  localparam rgb_t COLOR_GRASS = '{red: 8'd70,  green: 8'd160, blue: 8'd20};
  localparam rgb_t COLOR_DIRT  = '{red: 8'd130, green: 8'd50,  blue: 8'd16};
  localparam rgb_t COLOR_STONE = '{red: 8'd90,  green: 8'd80,  blue: 8'd70};
  localparam rgb_t COLOR_OTHER = '{red: 8'd255, green: 8'd0,   blue: 8'd0};

  // Face color for a solid block value
  function automatic rgb_t color_of(input logic [VALUE_W-1:0] value);
    rgb_t c;
    case (value)
      BLOCK_GRASS: c = COLOR_GRASS;
      BLOCK_DIRT:  c = COLOR_DIRT;
      BLOCK_STONE: c = COLOR_STONE;
      default:     c = COLOR_OTHER;
    endcase
    return c;
  endfunction

endpackage

// ----- design/vfc_nbr_unit.sv -----
// ----------------------------------------------------------------------------
// vfc_nbr_unit - shared neighbor address unit
// Steps one axis of a coordinate by one, checks the grid bounds and forms the
// voxel store address. Used for writes, the self read and all six neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vfc_nbr_unit #(
  parameter int unsigned GRID_X = vfc_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y = vfc_pkg::GRID_Y_DEF,
  parameter int unsigned GRID_Z = vfc_pkg::GRID_Z_DEF,
  localparam int unsigned ExtX  = (GRID_X < vfc_pkg::COORD_RANGE) ? GRID_X
                                                                  : vfc_pkg::COORD_RANGE,
  localparam int unsigned ExtY  = (GRID_Y < vfc_pkg::COORD_RANGE) ? GRID_Y
                                                                  : vfc_pkg::COORD_RANGE,
  localparam int unsigned ExtZ  = (GRID_Z < vfc_pkg::COORD_RANGE) ? GRID_Z
                                                                  : vfc_pkg::COORD_RANGE,
  localparam int unsigned BitsX = $clog2(ExtX),
  localparam int unsigned BitsY = $clog2(ExtY),
  localparam int unsigned BitsZ = $clog2(ExtZ),
  localparam int unsigned AddrW = BitsX + BitsY + BitsZ
) (
  input  vfc_pkg::nbr_req_t req_i,
  output logic [AddrW-1:0]  addr_o,
  output logic              oob_o
);
  import vfc_pkg::*;

  localparam logic [COORD_W:0] ExtXW = (COORD_W + 1)'(ExtX);
  localparam logic [COORD_W:0] ExtYW = (COORD_W + 1)'(ExtY);
  localparam logic [COORD_W:0] ExtZW = (COORD_W + 1)'(ExtZ);

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  axis_e              axis;
  logic               dir_pos;
  logic [COORD_W-1:0] coord;
  logic [COORD_W:0]   ext;
  logic [COORD_W:0]   stepped;
  logic               base_oob;
  logic               step_oob;
  logic [COORD_W-1:0] nx, ny, nz;

  // Decode face into axis and direction
  always_comb begin
    case (req_i.face)
      FACE_NEG_X: begin axis = AXIS_X; dir_pos = 1'b0; end
      FACE_POS_X: begin axis = AXIS_X; dir_pos = 1'b1; end
      FACE_NEG_Y: begin axis = AXIS_Y; dir_pos = 1'b0; end
      FACE_POS_Y: begin axis = AXIS_Y; dir_pos = 1'b1; end
      FACE_NEG_Z: begin axis = AXIS_Z; dir_pos = 1'b0; end
      FACE_POS_Z: begin axis = AXIS_Z; dir_pos = 1'b1; end
      default:    begin axis = AXIS_X; dir_pos = 1'b0; end
    endcase
  end

  // Select the stepped axis
  always_comb begin
    case (axis)
      AXIS_X:  begin coord = req_i.x; ext = ExtXW; end
      AXIS_Y:  begin coord = req_i.y; ext = ExtYW; end
      AXIS_Z:  begin coord = req_i.z; ext = ExtZW; end
      default: begin coord = req_i.x; ext = ExtXW; end
    endcase
  end

  // One increment or decrement, the step bound compare and the base bound check
  always_comb begin
    stepped  = dir_pos ? ({1'b0, coord} + 1'b1) : ({1'b0, coord} - 1'b1);
    step_oob = dir_pos ? (stepped >= ext) : (coord == '0);
    base_oob = ({1'b0, req_i.x} >= ExtXW) || ({1'b0, req_i.y} >= ExtYW) ||
               ({1'b0, req_i.z} >= ExtZW);
    oob_o    = base_oob || (!req_i.self_sel && step_oob);
  end

  // Substitute the stepped coordinate and pack the address
  always_comb begin
    nx = req_i.x;
    ny = req_i.y;
    nz = req_i.z;
    if (!req_i.self_sel) begin
      case (axis)
        AXIS_X:  nx = stepped[COORD_W-1:0];
        AXIS_Y:  ny = stepped[COORD_W-1:0];
        AXIS_Z:  nz = stepped[COORD_W-1:0];
        default: nx = req_i.x;
      endcase
    end
    addr_o = {nz[BitsZ-1:0], ny[BitsY-1:0], nx[BitsX-1:0]};
  end

endmodule

// ----- design/vfc_voxel_ram.sv -----
// ----------------------------------------------------------------------------
// vfc_voxel_ram - single-port voxel store
// One write or one registered read per cycle, 8-bit block values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vfc_voxel_ram #(
  parameter int unsigned ADDR_W = 15
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic                        re_i,
  input  logic [ADDR_W-1:0]           addr_i,
  input  logic [vfc_pkg::VALUE_W-1:0] wdata_i,
  output logic [vfc_pkg::VALUE_W-1:0] rdata_o
);
  import vfc_pkg::*;

  localparam int unsigned Depth = 1 << ADDR_W;

  logic [VALUE_W-1:0] mem [Depth];
  logic [VALUE_W-1:0] rdata_q;

  // Storage array, write has priority over read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/voxel_face_culling_core.sv -----
// ----------------------------------------------------------------------------
// voxel_face_culling_core - voxel hidden face culling
// Stores a voxel grid and emits the visible faces of a queried solid block.
// ----------------------------------------------------------------------------
// After reset the core sweeps the voxel store to zero, one entry per cycle
// (2**(bits of x + y + z) entries, 32768 at the default 32x32x32 grid), and
// stalls its input meanwhile. A write transaction is stored as it is taken. A
// query reads the block and its six neighbors from the single-port store, one
// read per cycle, then sends the visible faces, 0 to 6 of them, one per cycle
// while the output is not stalled. Queries outside the grid give nothing.
// Faces come in the order -x, +x, -y, +y, -z, +z, last set on the final one.
`timescale 1ns / 1ps

module voxel_face_culling_core #(
  parameter int unsigned GRID_X  = vfc_pkg::GRID_X_DEF,
  parameter int unsigned GRID_Y  = vfc_pkg::GRID_Y_DEF,
  parameter int unsigned GRID_Z  = vfc_pkg::GRID_Z_DEF,
  parameter int unsigned CHUNK_X = vfc_pkg::CHUNK_X_DEF,
  parameter int unsigned CHUNK_Z = vfc_pkg::CHUNK_Z_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  vfc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output vfc_pkg::out_item_t out_item_o
);
  import vfc_pkg::*;

  localparam int unsigned ExtX  = (GRID_X < COORD_RANGE) ? GRID_X : COORD_RANGE;
  localparam int unsigned ExtY  = (GRID_Y < COORD_RANGE) ? GRID_Y : COORD_RANGE;
  localparam int unsigned ExtZ  = (GRID_Z < COORD_RANGE) ? GRID_Z : COORD_RANGE;
  localparam int unsigned AddrW = $clog2(ExtX) + $clog2(ExtY) + $clog2(ExtZ);

  localparam logic [2:0] StepSelf     = 3'd0;
  localparam logic [2:0] StepLastRead = 3'd6;
  localparam logic [2:0] StepDone     = 3'd7;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [AddrW-1:0]     clr_addr_q, clr_addr_d;
  logic [2:0]           step_q, step_d;
  logic [COORD_W-1:0]   base_x_q, base_y_q, base_z_q;
  logic                 rd_pend_q, rd_pend_d;
  logic [2:0]           rd_step_q, rd_step_d;
  logic                 rd_oob_q, rd_oob_d;
  logic [VALUE_W-1:0]   self_q, self_d;
  logic [NUM_FACES-1:0] mask_q, mask_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_item_q, out_item_d;

  nbr_req_t             nbr_req;
  logic [AddrW-1:0]     nbr_addr;
  logic                 nbr_oob;

  logic                 ram_we, ram_re;
  logic [AddrW-1:0]     ram_addr;
  logic [VALUE_W-1:0]   ram_wdata, ram_rdata;

  logic                 in_accept;
  logic                 out_free;
  logic [2:0]           mask_idx;
  logic [FACE_W-1:0]    emit_idx;
  logic                 emit_found;
  logic [NUM_FACES-1:0] mask_left;
  rgb_t                 color;

  logic [LOCAL_W-1:0]   lx_tab [COORD_RANGE];
  logic [LOCAL_W-1:0]   lz_tab [COORD_RANGE];

  // Chunk-local position tables, resolved at elaboration
  for (genvar gi = 0; gi < COORD_RANGE; gi++) begin : g_local
    localparam int unsigned LxVal = (gi % CHUNK_X) % LOCAL_RANGE;
    localparam int unsigned LzVal = (gi % CHUNK_Z) % LOCAL_RANGE;
    assign lx_tab[gi] = LOCAL_W'(LxVal);
    assign lz_tab[gi] = LOCAL_W'(LzVal);
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Shared address unit request
  always_comb begin
    nbr_req.self_sel = 1'b1;
    nbr_req.face     = FACE_NEG_X;
    nbr_req.x        = base_x_q;
    nbr_req.y        = base_y_q;
    nbr_req.z        = base_z_q;
    if (state_q == ST_IDLE) begin
      nbr_req.x = in_item_i.pos_x;
      nbr_req.y = in_item_i.pos_y;
      nbr_req.z = in_item_i.pos_z;
    end else if (step_q != StepSelf) begin
      nbr_req.self_sel = 1'b0;
      nbr_req.face     = face_e'(step_q - 3'd1);
    end
  end

  vfc_nbr_unit #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y),
    .GRID_Z (GRID_Z)
  ) u_nbr (
    .req_i  (nbr_req),
    .addr_o (nbr_addr),
    .oob_o  (nbr_oob)
  );

  // Store port arbitration: clear sweep, write transaction or query read
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_addr  = nbr_addr;
    ram_wdata = in_item_i.block_value;
    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_we = in_accept && (in_item_i.kind == KIND_WRITE) && !nbr_oob;
      end
      ST_READ: begin
        ram_re = (step_q <= StepLastRead) && !nbr_oob;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  vfc_voxel_ram #(
    .ADDR_W (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Lowest remaining visible face
  always_comb begin
    emit_idx   = '0;
    emit_found = 1'b0;
    for (int i = 0; i < NUM_FACES; i++) begin
      if (mask_q[i] && !emit_found) begin
        emit_idx   = FACE_W'(i);
        emit_found = 1'b1;
      end
    end
    mask_left = mask_q & ~(NUM_FACES'(1) << emit_idx);
  end

  assign color    = color_of(self_q);
  assign mask_idx = rd_step_q - 3'd1;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    step_d      = step_q;
    rd_pend_d   = 1'b0;
    rd_step_d   = step_q;
    rd_oob_d    = nbr_oob;
    self_d      = self_q;
    mask_d      = mask_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;

    // Collect read data in the cycle after the read was issued
    if (rd_pend_q) begin
      if (rd_step_q == StepSelf) begin
        self_d = ram_rdata;
      end else begin
        mask_d[mask_idx] = rd_oob_q || (ram_rdata == '0);
      end
    end

    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (&clr_addr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        step_d = StepSelf;
        if (in_accept && (in_item_i.kind == KIND_QUERY) && !nbr_oob) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        step_d    = step_q + 1'b1;
        rd_pend_d = (step_q <= StepLastRead);
        if (step_q == StepDone) begin
          if ((self_d == '0) || (mask_d == '0)) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_item_d.face    = emit_idx;
          out_item_d.local_x = lx_tab[base_x_q];
          out_item_d.local_y = base_y_q;
          out_item_d.local_z = lz_tab[base_z_q];
          out_item_d.red     = color.red;
          out_item_d.green   = color.green;
          out_item_d.blue    = color.blue;
          out_item_d.last    = (mask_left == '0);
          mask_d             = mask_left;
          if (mask_left == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      step_q      <= StepSelf;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      step_q      <= step_d;
      rd_pend_q   <= rd_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      base_x_q <= in_item_i.pos_x;
      base_y_q <= in_item_i.pos_y;
      base_z_q <= in_item_i.pos_z;
    end
    rd_step_q  <= rd_step_d;
    rd_oob_q   <= rd_oob_d;
    self_q     <= self_d;
    mask_q     <= mask_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- design/vfc_checker.sv -----
// ----------------------------------------------------------------------------
// vfc_checker - port-level assertions for the voxel face culling core
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vfc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input vfc_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input vfc_pkg::out_item_t out_item_o
);
  import vfc_pkg::*;

  // A stalled input transaction stays offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("input transaction changed while stalled");

  // A stalled output transaction stays offered
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // A stalled output payload does not change
  a_out_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("output payload changed while stalled");

  // Face codes stay within the six directions
  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.face <= FACE_W'(FACE_POS_Z)))
    else $error("face code out of range");

  // While a query still has faces to send, no new input is taken
  a_busy_mid_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> in_stall_o)
    else $error("input accepted in the middle of a query");

endmodule

bind voxel_face_culling_core vfc_checker u_vfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
